>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file tws_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is asserted
`define TWS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising edge, reset included
`define TWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tws_pkg.sv
`default_nettype none

package tws_pkg;

    // timestamp and window width in ticks
    localparam int TIME_BITS = 32;
    // running sum width, wraps modulo 2^SUM_BITS
    localparam int SUM_BITS  = 32;

endpackage

`default_nettype wire

>>> hw/rtl/time_windowed_moving_sum.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+----------------------------------------
// s_*       | in        | s_valid / s_ready  | s_sample_time, s_sample_value, s_first
// m_*       | out       | m_valid / m_ready  | m_window_sum, m_dropped
// cfg_*     | in        | cfg_wr_en          | cfg_wr_data (window length in ticks)
//
// a transaction passes ST_IDLE and ST_FETCH, then ST_EVAL once per stored entry examined (skipped
// with an empty ring; ends at the first entry kept or when every entry ages out), ST_INSERT, ST_DONE
// the ring has a single registered read port, so one stored entry is examined per cycle
// synchronous active-low reset, no clearing pass: ring contents need none
// a finished result sits in the output register while the next transaction is taken;
// only a second result with the first still waiting holds the block in its last state
`default_nettype none

module time_windowed_moving_sum #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 24
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [tws_pkg::TIME_BITS-1:0]    cfg_wr_data,
    // sample input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tws_pkg::TIME_BITS-1:0]    s_sample_time,
    input  wire logic signed [VALUE_BITS-1:0]     s_sample_value,
    input  wire logic                             s_first,
    // result output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [tws_pkg::SUM_BITS-1:0]   m_window_sum,
    output logic                                  m_dropped
);
    import tws_pkg::*;

    localparam int PW  = $clog2(DEPTH);     // ring pointer
    localparam int CW  = $clog2(DEPTH + 1); // fill count, holds DEPTH itself
    localparam int SLW = PW + 1;            // pointer plus count before wrap

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a sample
        ST_FETCH,   // read of the oldest entry in flight
        ST_EVAL,    // age test on the oldest entry, evict or stop
        ST_INSERT,  // append the new sample, overwrite oldest if full
        ST_DONE     // hand the result to the output register
    } state_t;

    state_t                       state_reg, state_next;
    logic [TIME_BITS-1:0]         wl_reg, wl_next;
    logic [PW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [SUM_BITS-1:0]          sum_reg, sum_next;
    logic                         m_valid_reg, m_valid_next;
    logic [SUM_BITS-1:0]          m_sum_reg, m_sum_next;
    logic                         m_drop_reg, m_drop_next;

    // payload registers, no reset needed
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic                         dropped_reg, dropped_next;

    // ring port
    logic                         wr_en;
    logic [PW-1:0]                rd_addr;
    logic [TIME_BITS-1:0]         rd_time;
    logic signed [VALUE_BITS-1:0] rd_value;

    logic [PW-1:0]                ptr_inc;
    logic [SLW-1:0]               slot_sum;
    logic [PW-1:0]                slot;
    logic                         stale;
    logic [SUM_BITS-1:0]          rd_value_ext;
    logic [SUM_BITS-1:0]          val_ext;

    tws_ring #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ring (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (slot),
        .wr_time  (now_reg),
        .wr_value (val_reg),
        .rd_addr  (rd_addr),
        .rd_time  (rd_time),
        .rd_value (rd_value)
    );

    // ring pointer arithmetic, DEPTH need not be a power of two
    assign ptr_inc  = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
    assign slot_sum = SLW'(ptr_reg) + SLW'(count_reg);
    assign slot     = (slot_sum >= SLW'(DEPTH)) ? PW'(slot_sum - SLW'(DEPTH))
                                                : PW'(slot_sum);

    // oldest entry is out of the window when its time plus window is at most now,
    // compared in 33 bits so the sum cannot wrap
    assign stale = ({1'b0, rd_time} + {1'b0, wl_reg}) <= {1'b0, now_reg};

    assign rd_value_ext = SUM_BITS'(rd_value);
    assign val_ext      = SUM_BITS'(val_reg);

    always_comb begin
        state_next   = state_reg;
        wl_next      = wl_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        now_next     = now_reg;
        val_next     = val_reg;
        dropped_next = dropped_reg;
        m_sum_next   = m_sum_reg;
        m_drop_next  = m_drop_reg;
        wr_en        = 1'b0;
        rd_addr      = ptr_reg;

        // the user must write the window length only while idle; the block itself does not enforce it
        if (cfg_wr_en) begin
            wl_next = cfg_wr_data;
        end

        // result taken downstream
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next     = s_sample_time;
                    val_next     = s_sample_value;
                    dropped_next = 1'b0;
                    // start of a new series wipes the history
                    if (s_first) begin
                        ptr_next   = '0;
                        count_next = '0;
                        sum_next   = '0;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // read of the oldest entry goes out this cycle
                if (count_reg == '0) begin
                    state_next = ST_INSERT;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stale) begin
                    sum_next   = sum_reg - rd_value_ext;
                    ptr_next   = ptr_inc;
                    count_next = count_reg - CW'(1);
                    // prefetch the next oldest entry
                    rd_addr    = ptr_inc;
                    if (count_reg == CW'(1)) begin
                        state_next = ST_INSERT;
                    end
                end else begin
                    // keep the oldest entry on the read port for a full-ring overwrite
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                // a zero window leaves the new sample outside its own window
                if (wl_reg != '0) begin
                    wr_en = 1'b1;
                    if (count_reg == CW'(DEPTH)) begin
                        // full ring: oldest entry is overwritten in place
                        ptr_next     = ptr_inc;
                        sum_next     = sum_reg - rd_value_ext + val_ext;
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                        sum_next   = sum_reg + val_ext;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = sum_reg;
                    m_drop_next  = dropped_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= '0;
            ptr_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_sum_reg   <= '0;
            m_drop_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wl_reg      <= wl_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            m_sum_reg   <= m_sum_next;
            m_drop_reg  <= m_drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        val_reg     <= val_next;
        dropped_reg <= dropped_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_window_sum = m_sum_reg;
    assign m_dropped    = m_drop_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tws_ring.sv
`default_nettype none

module tws_ring #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  wire logic [tws_pkg::TIME_BITS-1:0]  wr_time,
    input  wire logic signed [VALUE_BITS-1:0]   wr_value,
    input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [tws_pkg::TIME_BITS-1:0]       rd_time,
    output logic signed [VALUE_BITS-1:0]        rd_value
);
    import tws_pkg::*;

    logic [TIME_BITS-1:0]         time_mem  [DEPTH];
    logic signed [VALUE_BITS-1:0] value_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr]  <= wr_time;
            value_mem[wr_addr] <= wr_value;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_time  <= time_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tws_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tws_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic signed [tws_pkg::SUM_BITS-1:0] m_window_sum,
    input  wire logic                              m_dropped
);
    import tws_pkg::*;

    // result held while stalled
    `TWS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_window_sum) && $stable(m_dropped), "result changed while stalled")

    // no result right after reset
    `TWS_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // block is busy for the cycle after taking a sample
    `TWS_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready right after accept")

    // a new result only appears at the end of a busy period
    `TWS_ASSERT(a_result_from_busy, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result without prior work")

endmodule

bind time_windowed_moving_sum tws_checker u_tws_checker (.*);

`default_nettype wire

>>> tb/moving_sum_checker.sv
`timescale 1ns / 100ps

module moving_sum_checker #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 24
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tws_pkg::TIME_BITS-1:0]       cfg_wr_data,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [tws_pkg::TIME_BITS-1:0]       s_sample_time,
    input  wire logic signed [VALUE_BITS-1:0]        s_sample_value,
    input  wire logic                                s_first,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic signed [tws_pkg::SUM_BITS-1:0] m_window_sum,
    input  wire logic                                m_dropped,
    output int                                       mismatch_count,
    output int                                       results_pending
);
    import tws_pkg::*;

    typedef struct packed {
        logic [SUM_BITS-1:0] window_sum;
        logic                dropped;
    } window_result_t;

    // retained samples, oldest first, values kept sign-extended
    logic [TIME_BITS-1:0] stamp_ring [DEPTH];
    logic [SUM_BITS-1:0]  value_ring [DEPTH];
    int unsigned          oldest_idx;
    int unsigned          held_count;
    logic [SUM_BITS-1:0]  sum_acc;
    logic [TIME_BITS-1:0] window_ticks;

    window_result_t expected_sums [$];

    // 33-bit compare so stamp + window never wraps
    function automatic logic aged_out(input logic [TIME_BITS-1:0] stamp,
                                      input logic [TIME_BITS-1:0] now);
        return ({1'b0, stamp} + {1'b0, window_ticks}) <= {1'b0, now};
    endfunction

    task automatic retire_oldest();
        sum_acc    = sum_acc - value_ring[oldest_idx];
        oldest_idx = (oldest_idx + 1) % DEPTH;
        held_count = held_count - 1;
    endtask

    task automatic predict_window_sum(input  logic [TIME_BITS-1:0]  now,
                                      input  logic signed [VALUE_BITS-1:0] value,
                                      input  logic                  restart,
                                      output window_result_t        result);
        logic signed [SUM_BITS-1:0] wide_value;
        int unsigned                slot;
        logic                       lost;
        wide_value = value;
        lost = 1'b0;
        if (restart) begin
            oldest_idx = 0;
            held_count = 0;
            sum_acc    = '0;
        end
        while (held_count > 0 && aged_out(stamp_ring[oldest_idx], now))
            retire_oldest();
        // zero window: the sample is outside its own window and is not kept
        if (!aged_out(now, now)) begin
            if (held_count >= DEPTH) begin
                retire_oldest();
                lost = 1'b1;
            end
            slot = (oldest_idx + held_count) % DEPTH;
            stamp_ring[slot] = now;
            value_ring[slot] = wide_value;
            held_count = held_count + 1;
            sum_acc = sum_acc + wide_value;
        end
        result.window_sum = sum_acc;
        result.dropped    = lost;
    endtask

    always @(posedge aclk) begin : watch
        window_result_t got;
        window_result_t want;
        if (!aresetn) begin
            oldest_idx   = 0;
            held_count   = 0;
            sum_acc      = '0;
            window_ticks = '0;
            expected_sums.delete();
        end else begin
            if (cfg_wr_en)
                window_ticks = cfg_wr_data;
            if (m_valid && m_ready) begin
                got.window_sum = m_window_sum;
                got.dropped    = m_dropped;
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result transaction, window_sum %0d dropped %0b",
                             $time, $signed(got.window_sum), got.dropped);
                    mismatch_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got.window_sum !== want.window_sum) begin
                        $display("%0t: window_sum expected %0d actual %0d", $time,
                                 $signed(want.window_sum), $signed(got.window_sum));
                        mismatch_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b", $time,
                                 want.dropped, got.dropped);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_window_sum(s_sample_time, s_sample_value, s_first, want);
                expected_sums.push_back(want);
            end
        end
        results_pending = expected_sums.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tws_pkg::*;

    localparam int RING_DEPTH  = 256;
    localparam int SAMPLE_BITS = 24;

    // window, tick and sample value extremes
    localparam logic [TIME_BITS-1:0] WINDOW_NONE = '0;
    localparam logic [TIME_BITS-1:0] WINDOW_MAX  = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
    localparam logic signed [SAMPLE_BITS-1:0] VALUE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] VALUE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD   = 400;
    // after the last result: longest eviction run plus pipeline depth
    localparam int TAIL_CYCLES = RING_DEPTH + 50;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_wr_en   = 1'b0;
    logic [TIME_BITS-1:0]          cfg_wr_data = '0;

    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [TIME_BITS-1:0]          s_sample_time  = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_value = '0;
    logic                          s_first        = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SUM_BITS-1:0]    m_window_sum;
    logic                          m_dropped;

    int mismatch_count;
    int results_pending;

    // sample transactions accepted so far; drives the idle schedule
    int sent_count = 0;
    // long hold-off requests from the sender, served by the receiver process
    int hold_asked   = 0;
    int hold_granted = 0;
    int hold_left    = 0;

    always #4 aclk = ~aclk;

    time_windowed_moving_sum #(
        .DEPTH     (RING_DEPTH),
        .VALUE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_time (s_sample_time),
        .s_sample_value(s_sample_value),
        .s_first       (s_first),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_sum  (m_window_sum),
        .m_dropped     (m_dropped)
    );

    moving_sum_checker #(
        .DEPTH     (RING_DEPTH),
        .VALUE_BITS(SAMPLE_BITS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_time  (s_sample_time),
        .s_sample_value (s_sample_value),
        .s_first        (s_first),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_sum   (m_window_sum),
        .m_dropped      (m_dropped),
        .mismatch_count (mismatch_count),
        .results_pending(results_pending)
    );

    // idle schedule: sender light / receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        return (sent_count < 140) ? 15 : (sent_count < 280) ? 63 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (sent_count < 140) ? 63 : (sent_count < 280) ? 15 : 0;
    endfunction

    // result side: random back-pressure, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_asked) begin
            m_ready      <= 1'b0;
            hold_left    <= LONG_HOLD;
            hold_granted <= hold_asked;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // one sample transaction: optional idle gap, then hold valid until taken
    task automatic send_sample(input logic [TIME_BITS-1:0]          stamp,
                               input logic signed [SAMPLE_BITS-1:0] value,
                               input logic                          restart);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_sample_time  <= stamp;
        s_sample_value <= value;
        s_first        <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
    endtask

    task automatic set_window(input logic [TIME_BITS-1:0] ticks);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // one series: first flag on entry, mostly nondecreasing times, a few steps back;
    // hold_at / pause_at pick items after which the pressure events fire (-1 for none)
    task automatic send_series(input int len, input int unsigned step_max,
                               input int hold_at, input int pause_at);
        logic [TIME_BITS-1:0]          stamp;
        logic signed [SAMPLE_BITS-1:0] value;
        int unsigned                   pick;
        // sometimes start near the top of the tick range so later steps wrap
        if ($urandom_range(0, 3) == 0)
            stamp = TIME_MAX - $urandom_range(0, step_max * 4);
        else
            stamp = $urandom;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (i > 0) begin
                if (pick < 5)
                    stamp = stamp - $urandom_range(0, step_max * 2);
                else
                    stamp = stamp + $urandom_range(0, step_max);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                value = VALUE_MAX;
            else if (pick < 20)
                value = VALUE_MIN;
            else
                value = SAMPLE_BITS'($urandom);
            send_sample(stamp, value, i == 0);
            if (i == hold_at)
                hold_asked++;
            if (i == pause_at)
                drain_results();
        end
    endtask

    // several short series plus stray noise transactions under one window setting
    task automatic send_series_mix(input int total, input int unsigned step_max,
                                   input int len_max);
        int target;
        target = sent_count + total;
        while (sent_count < target) begin
            if ($urandom_range(0, 4) == 0)
                send_sample($urandom, SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
            else
                send_series($urandom_range(2, len_max), step_max, -1, -1);
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // zero window: nothing is ever retained, sum stays 0
        set_window(WINDOW_NONE);
        send_sample('0, VALUE_MAX, 1'b1);
        send_sample(TIME_MAX, VALUE_MIN, 1'b0);
        send_sample(32'd5, 24'sd1, 1'b0);

        // short window: eviction, time going backwards, top of tick range
        set_window(32'd10);
        send_sample(32'd100, VALUE_MAX, 1'b1);
        send_sample(32'd105, VALUE_MIN, 1'b0);
        send_sample(32'd109, 24'sd3, 1'b0);
        send_sample(32'd110, 24'sd7, 1'b0);
        send_sample(32'd90, 24'sd5, 1'b0);
        send_sample(32'd200, 24'sd1, 1'b0);
        send_sample(TIME_MAX, 24'sd2, 1'b1);
        send_sample(TIME_MAX, 24'sd4, 1'b0);
        send_sample('0, 24'sd6, 1'b0);
        send_sample(32'd50, 24'sd8, 1'b1);

        // widest window: only stamp 0 ages out, and only at the last tick
        set_window(WINDOW_MAX);
        send_sample('0, 24'sd1, 1'b1);
        send_sample(TIME_MAX - 1, 24'sd2, 1'b0);
        send_sample(TIME_MAX, 24'sd3, 1'b0);

        // one long series past the ring depth: full-ring drops, big sums;
        // long receiver hold-off midway, then a full drain by the sender
        send_series(290, 3, 100, 200);

        set_window(32'd50);
        send_series_mix(40, 20, 15);

        set_window($urandom_range(1, 1000));
        send_series_mix(40, 200, 15);

        set_window(32'd1);
        send_series_mix(20, 2, 10);

        set_window($urandom);
        send_series_mix(20, 32'h1000_0000, 10);

        set_window(WINDOW_NONE);
        send_series_mix(15, 5, 8);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ring.sv
hw/rtl/time_windowed_moving_sum.sv
hw/rtl/tws_checker.sv
tb/moving_sum_checker.sv
tb/tb_top.sv
